@@ hdl/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every rising edge outside reset
`define URMKD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every rising edge, reset included
`define URMKD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/urmkd_pkg.sv @@
package urmkd_pkg;

   localparam int MIX_CELLS = 24;
   localparam int K_COUNT   = MIX_CELLS + 2;

   localparam logic OP_PASSWORD = 1'b0;
   localparam logic OP_PACK     = 1'b1;

   localparam logic [31:0] MIX_K [K_COUNT] = '{
      32'h6D835AFC, 32'h7D15CD97, 32'h0942B409, 32'h32F9C923, 32'hA811FB02,
      32'h64F121E8, 32'hD1CC8B4E, 32'hE8873E6F, 32'h61399BBB, 32'hF1B91926,
      32'hAC661520, 32'hA21A31C9, 32'hD424808D, 32'hFE118E07, 32'hD18E728D,
      32'hABAC9E17, 32'h18066433, 32'h00E18E79, 32'h65A77305, 32'h5AE9E297,
      32'h11FC628C, 32'h7BB3431F, 32'h942A8308, 32'hB2F8FD20, 32'h5728B869,
      32'h30726D5A
   };

   localparam logic [15:0] PACK_XOR = 16'h5555;

   typedef struct packed {
      logic        valid;
      logic        opcode;
      logic [31:0] p;
      logic [31:0] q;
   } stage_type;

endpackage

@@ hdl/urmkd_front.sv @@
module urmkd_front
   import urmkd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic        in_valid,
   input  logic [55:0] uid,
   input  logic        opcode,
   output stage_type   stage_out
);

   logic [7:0]  u_byte [8];
   logic [7:0]  buf_byte [8];
   logic [2:0]  offset;
   logic [2:0]  src;
   stage_type   stage_ff;
   stage_type   stage_in;

   always_comb begin
      for (int i = 0; i < 7; i++) begin
         u_byte[i] = uid[8*(6-i) +: 8];
      end
      u_byte[7] = 8'h00;
      if (opcode == OP_PASSWORD) begin
         offset = u_byte[1][2:0] + u_byte[3][2:0] + u_byte[5][2:0];
      end else begin
         offset = u_byte[2][2:0] + u_byte[5][2:0];
      end
      src = 3'd0;
      for (int j = 0; j < 8; j++) begin
         src         = 3'(j) - offset;
         buf_byte[j] = u_byte[src];
      end
      stage_in.valid  = in_valid;
      stage_in.opcode = opcode;
      stage_in.p = {buf_byte[3], buf_byte[2], buf_byte[1], buf_byte[0]} + MIX_K[0];
      stage_in.q = {buf_byte[7], buf_byte[6], buf_byte[5], buf_byte[4]} + MIX_K[1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (advance) begin
         stage_ff.opcode <= stage_in.opcode;
         stage_ff.p      <= stage_in.p;
         stage_ff.q      <= stage_in.q;
      end
   end

   assign stage_out = stage_ff;

endmodule

@@ hdl/urmkd_mix_cell.sv @@
module urmkd_mix_cell
   import urmkd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  logic [31:0] k_value,
   input  stage_type   stage_in,
   output stage_type   stage_out
);

   logic [31:0] mixed;
   logic [63:0] doubled;
   logic [31:0] t_in;
   stage_type   stage_ff;

   // t = rotl(p ^ q, q) + k, pair moves on as (q, t)
   always_comb begin
      mixed   = stage_in.p ^ stage_in.q;
      doubled = {mixed, mixed} << stage_in.q[4:0];
      t_in    = doubled[63:32] + k_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= stage_in.valid;
      end
      if (advance) begin
         stage_ff.opcode <= stage_in.opcode;
         stage_ff.p      <= stage_in.q;
         stage_ff.q      <= t_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

@@ hdl/urmkd_back.sv @@
module urmkd_back
   import urmkd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  stage_type   stage_in,
   output logic        out_valid,
   output logic [31:0] out_value
);

   logic [7:0]  m_byte [8];
   logic [1:0]  start;
   logic [10:0] byte_sum;
   logic [15:0] scaled;
   logic [15:0] pack_q;
   logic [31:0] value_in;
   logic        valid_ff;
   logic [31:0] value_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         m_byte[i]   = stage_in.p[8*i +: 8];
         m_byte[i+4] = stage_in.q[8*i +: 8];
      end
      start = m_byte[0][1:0] + m_byte[2][1:0] + m_byte[4][1:0] + m_byte[6][1:0];
      byte_sum = 11'd0;
      for (int i = 0; i < 8; i++) begin
         byte_sum = byte_sum + 11'(m_byte[i]);
      end
      scaled = {2'b00, byte_sum, 3'b000} + {3'b000, byte_sum, 2'b00} + {5'b00000, byte_sum};
      pack_q = scaled ^ PACK_XOR;
      if (stage_in.opcode == OP_PASSWORD) begin
         value_in = {m_byte[3'(start) + 3'd3], m_byte[3'(start) + 3'd2],
                     m_byte[3'(start) + 3'd1], m_byte[3'(start)]};
      end else begin
         value_in = {16'h0000, pack_q[7:0], pack_q[15:8]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff <= value_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_value = value_ff;

endmodule

@@ hdl/uid_rotate_mix_key_derivation.sv @@
// Derives a 32-bit password or a 16-bit pack value from a 7-byte tag UID.
// Request channel: req_tdata carries the UID, req_tuser selects the result
// (0 password, 1 pack). Response channel: rsp_tdata carries the derived
// value, the pack in its low 16 bits with the upper bits zero.
// The UID is placed at its rotation offset and the initial constants are
// added in a front stage, then the word pair runs through a row of 24 mix
// cells, one mix step per cell, and the result is formed in an output
// register. Throughput is one transaction per cycle while the receiver
// does not stall; each cell holds one transaction in flight, so up to 26
// are in the row at once.
// When the receiver stalls with rsp_tvalid high, the whole row holds and
// req_tready falls; it rises again in the cycle the result is taken.
// Synchronous reset empties the row; no other state is kept.
`include "assert_macros.svh"

module uid_rotate_mix_key_derivation
   import urmkd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // uid[55:0]
   input  logic        req_tuser,   // opcode[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // derived_value[31:0]
);

   logic      advance;
   stage_type chain [MIX_CELLS+1];

   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   urmkd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .uid       (req_tdata),
      .opcode    (req_tuser),
      .stage_out (chain[0])
   );

   for (genvar gi = 0; gi < MIX_CELLS; gi++) begin : g_cell
      urmkd_mix_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .k_value   (MIX_K[gi+2]),
         .stage_in  (chain[gi]),
         .stage_out (chain[gi+1])
      );
   end

   urmkd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .stage_in  (chain[MIX_CELLS]),
      .out_valid (rsp_tvalid),
      .out_value (rsp_tdata)
   );

   `URMKD_ASSERT(a_accept_enters_row, clock, reset, req_tvalid && req_tready |=> chain[0].valid, "accepted transaction missing from front stage")
   `URMKD_ASSERT(a_last_cell_holds, clock, reset, chain[MIX_CELLS].valid && !advance |=> chain[MIX_CELLS].valid && $stable(chain[MIX_CELLS].q), "last cell lost data during stall")
   `URMKD_ASSERT(a_result_from_row, clock, reset, advance && !chain[MIX_CELLS].valid |=> !rsp_tvalid, "response without transaction in row")
   `URMKD_ASSERT_ALWAYS(a_reset_empties, clock, $past(reset) |-> !rsp_tvalid && !chain[0].valid, "row not empty after reset")

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
   import urmkd_pkg::*;

   localparam int CLOCK_HALF    = 10;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLD     = 300;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic [55:0] uid;
      logic        opcode;
      logic [31:0] value;
   } key_expect_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   key_expect_type pending_keys [$];
   int          mismatches = 0;
   int          cycle_count = 0;
   bit          req_gaps_on = 1'b1;
   bit          rsp_stalls_on = 1'b1;
   int          rsp_hold_request = 0;

   uid_rotate_mix_key_derivation i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic logic [31:0] rotl32(logic [31:0] x, logic [4:0] n);
      return (x << n) | (x >> (6'd32 - n));
   endfunction

   function automatic logic [31:0] derive_key(logic [55:0] uid, logic op);
      logic [7:0]  ub [7];
      logic [7:0]  mb [8];
      logic [2:0]  rot;
      logic [1:0]  sel;
      logic [31:0] wa, wb, t1, t2, acc;
      int          k;
      for (int i = 0; i < 7; i++) ub[i] = uid[8 * (6 - i) +: 8];
      if (op == OP_PASSWORD) rot = 3'(ub[1] + ub[3] + ub[5]);
      else rot = 3'(ub[2] + ub[5]);
      for (int i = 0; i < 8; i++) mb[i] = 8'h00;
      for (int i = 0; i < 7; i++) mb[3'(i + rot)] = ub[i];
      wa = {mb[3], mb[2], mb[1], mb[0]} + MIX_K[0];
      wb = {mb[7], mb[6], mb[5], mb[4]} + MIX_K[1];
      k = 2;
      repeat (MIX_CELLS / 4) begin
         t1 = rotl32(wa ^ wb, wb[4:0]) + MIX_K[k];
         t2 = rotl32(wb ^ t1, t1[4:0]) + MIX_K[k + 1];
         wa = rotl32(t1 ^ t2, t2[4:0]) + MIX_K[k + 2];
         wb = rotl32(t2 ^ wa, wa[4:0]) + MIX_K[k + 3];
         k += 4;
      end
      {mb[3], mb[2], mb[1], mb[0]} = wa;
      {mb[7], mb[6], mb[5], mb[4]} = wb;
      if (op == OP_PASSWORD) begin
         sel = 2'(mb[0] + mb[2] + mb[4] + mb[6]);
         return {mb[sel + 3], mb[sel + 2], mb[sel + 1], mb[sel]};
      end
      acc = 0;
      for (int i = 0; i < 8; i++) acc += mb[i] * 13;
      acc ^= PACK_XOR;
      return {16'h0000, acc[7:0], acc[15:8]};
   endfunction

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 19);
      if (roll < 12) return 0;
      else if (roll < 19) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   initial begin
      clock = 1'b0;
      forever #(CLOCK_HALF) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      bit ready_next;
      int span;
      rsp_tready = 1'b0;
      @(posedge clock);
      forever begin
         if (rsp_hold_request != 0) begin
            ready_next = 1'b0;
            span = rsp_hold_request;
            rsp_hold_request = 0;
         end else if (!rsp_stalls_on || $urandom_range(0, 3) != 0) begin
            ready_next = 1'b1;
            span = $urandom_range(1, 8);
         end else begin
            ready_next = 1'b0;
            span = pick_gap() + 1;
         end
         rsp_tready <= ready_next;
         repeat (span) @(posedge clock);
      end
   end

   // handshake signals are stable at the falling edge
   always @(negedge clock) begin
      key_expect_type head;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_keys.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected result: derived_value %h", rsp_tdata);
         end else begin
            head = pending_keys.pop_front();
            if (rsp_tdata !== head.value) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("derived_value mismatch: uid %h op %0d expected %h actual %h",
                           head.uid, head.opcode, head.value, rsp_tdata);
            end
         end
      end
   end

   task automatic send_uid(input logic [55:0] uid, input logic op);
      key_expect_type entry;
      int             gap;
      req_tvalid <= 1'b1;
      req_tdata  <= uid;
      req_tuser  <= op;
      @(negedge clock);
      while (!req_tready) @(negedge clock);
      @(posedge clock);
      entry.uid    = uid;
      entry.opcode = op;
      entry.value  = derive_key(uid, op);
      pending_keys.push_back(entry);
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drain();
      while (pending_keys.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic test_directed();
      send_uid('0, OP_PASSWORD);
      send_uid('0, OP_PACK);
      send_uid({56{1'b1}}, OP_PASSWORD);
      send_uid({56{1'b1}}, OP_PACK);
      send_uid(56'hAA55AA55AA55AA, OP_PASSWORD);
      send_uid(56'h55AA55AA55AA55, OP_PACK);
      // every rotation offset for both operations
      for (int r = 0; r < 8; r++) begin
         send_uid({8'h00, 8'(r), 40'h0}, OP_PASSWORD);
         send_uid({16'h0000, 8'(r), 32'h0}, OP_PACK);
      end
   endtask

   task automatic test_random(input int count);
      logic [63:0] raw;
      for (int i = 0; i < count; i++) begin
         raw = {$urandom, $urandom};
         send_uid(raw[55:0], 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_backpressure();
      rsp_stalls_on = 1'b0;
      req_gaps_on = 1'b0;
      rsp_hold_request = LONG_HOLD;
      test_random(60);
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
   endtask

   task automatic test_pause();
      req_tvalid <= 1'b0;
      wait_drain();
      test_random(40);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(200);
      test_backpressure();
      test_pause();
      test_random(80);
      req_tvalid <= 1'b0;
      wait_drain();
      if (mismatches == 0 && pending_keys.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ uid_rotate_mix_key_derivation.f @@
+incdir+hdl
hdl/urmkd_pkg.sv
hdl/urmkd_front.sv
hdl/urmkd_mix_cell.sv
hdl/urmkd_back.sv
hdl/uid_rotate_mix_key_derivation.sv
test/tb_top.sv
